[hw/rtl/lcdseq_pkg.sv]
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Types, register indexes, phase codes and constant tables shared by the
// character LCD 4-bit write sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdseq_pkg;

   // configuration register indexes
   localparam logic [3:0] CSR_UNIT_TICKS = 4'd0;
   localparam logic [3:0] CSR_LONG_WAIT  = 4'd1;

   localparam logic [15:0] UNIT_TICKS_RESET = 16'd1000;
   localparam logic [7:0]  LONG_WAIT_RESET  = 8'd50;

   // init step numbering
   localparam logic [6:0] STEP_FIRST_CMD    = 7'd4;
   localparam logic [6:0] STEP_GLYPH_START  = 7'd9;
   localparam logic [6:0] STEP_LAST_WAKE    = 7'd3;
   localparam logic [6:0] STEP_LAST_GAP     = 7'd2;

   localparam logic [3:0] WAKE_NIBBLE       = 4'h3;
   localparam logic [3:0] FOUR_BIT_NIBBLE   = 4'h2;
   localparam logic [7:0] CMD_DDRAM_HOME    = 8'h80;

   typedef enum logic [3:0] {
      PH_PWR_WAIT = 4'd0,
      PH_NIB_L1   = 4'd1,
      PH_NIB_H    = 4'd2,
      PH_NIB_L2   = 4'd3,
      PH_GAP      = 4'd4,
      PH_HI_L1    = 4'd5,
      PH_HI_H     = 4'd6,
      PH_HI_L2    = 4'd7,
      PH_LO_L1    = 4'd8,
      PH_LO_H     = 4'd9,
      PH_LO_L2    = 4'd10,
      PH_BUSY     = 4'd11,
      PH_IDLE     = 4'd12
   } phase_type;

   typedef struct packed {
      logic       write_request;
      logic       register_select;
      logic [7:0] byte_value;
      logic       busy_pin;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic       ready_res;
      logic       rs_level;
      logic       rw_level;
      logic       enable_level;
      logic [3:0] data_nibble;
      logic       data_drive;
   } rsp_type;

   // function set, display on, clear, entry mode, cgram address
   function automatic logic [7:0] init_cmd(input logic [2:0] idx);
      logic [7:0] val;
      case (idx)
         3'd0:    val = 8'h28;
         3'd1:    val = 8'h0C;
         3'd2:    val = 8'h01;
         3'd3:    val = 8'h06;
         3'd4:    val = 8'h40;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   // eight glyphs of eight rows; glyph 0 is a face, then five bar-graph cells, then two blanks
   function automatic logic [7:0] glyph_byte(input logic [5:0] idx);
      logic [7:0] val;
      case (idx[5:3])
         3'd0: begin
            case (idx[2:0])
               3'd0:    val = 8'h11;
               3'd1:    val = 8'h0A;
               3'd2:    val = 8'h04;
               3'd3:    val = 8'h1B;
               3'd7:    val = 8'h0E;
               default: val = 8'h11;
            endcase
         end
         3'd1:    val = 8'h10;
         3'd2:    val = 8'h18;
         3'd3:    val = 8'h1C;
         3'd4:    val = 8'h1E;
         3'd5:    val = 8'h1F;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/char_lcd_nibble_write_sequencer.sv]
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Character LCD 4-bit interface controller. Each req_ word is one timer tick
// with an optional byte offer and the sampled busy line; each rsp_ word gives
// the pin levels in force during that tick, plus accepted and ready flags.
//
// Exactly one rsp_ word comes out for every req_ word, in order. A pushed word
// sits in a two-entry input queue, the pin sequencer steps once per word, and
// the result goes into a two-entry output queue, from which it is popped. One
// word per cycle is sustained in both directions while the receiver keeps
// popping, set by the single sequencer step per cycle.
// When the receiver stops popping, the output queue fills, the sequencer holds
// and req_full rises once the input queue is full; nothing is dropped.
// After reset the sequencer starts the power-up wait, wake nibbles, command
// set and glyph load, counted in ticks, then reports ready. Configuration
// (unit tick count, long wait units) must go via csr_ while idle; unchecked.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_write_sequencer #(
   parameter int GLYPH_ROM_BYTES = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [3:0]  csr_index,
   input  wire logic [15:0] csr_write_data,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic        req_write_request,
   input  wire logic        req_register_select,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic        req_busy_pin,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic             rsp_accepted,
   output logic             rsp_ready_res,
   output logic             rsp_rs_level,
   output logic             rsp_rw_level,
   output logic             rsp_enable_level,
   output logic [3:0]       rsp_data_nibble,
   output logic             rsp_data_drive
);

   import lcdseq_pkg::*;

   req_type in_word, core_item;
   rsp_type core_result, out_word;
   logic    in_empty, out_full, step;

   assign in_word.write_request   = req_write_request;
   assign in_word.register_select = req_register_select;
   assign in_word.byte_value      = req_byte_value;
   assign in_word.busy_pin        = req_busy_pin;

   assign step = !in_empty && !out_full;

   lcdseq_fifo #(
      .WIDTH($bits(req_type))
   ) u_in_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (in_word),
      .full      (req_full),
      .pop       (step),
      .pop_data  (core_item),
      .empty     (in_empty)
   );

   lcdseq_core #(
      .GLYPH_ROM_BYTES(GLYPH_ROM_BYTES)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .step             (step),
      .item             (core_item),
      .result           (core_result)
   );

   lcdseq_fifo #(
      .WIDTH($bits(rsp_type))
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .push_data (core_result),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_word),
      .empty     (rsp_empty)
   );

   assign rsp_accepted     = out_word.accepted;
   assign rsp_ready_res    = out_word.ready_res;
   assign rsp_rs_level     = out_word.rs_level;
   assign rsp_rw_level     = out_word.rw_level;
   assign rsp_enable_level = out_word.enable_level;
   assign rsp_data_nibble  = out_word.data_nibble;
   assign rsp_data_drive   = out_word.data_drive;

endmodule

`default_nettype wire

[hw/rtl/lcdseq_fifo.sv]
// ----------------------------------------------------------------------------
// lcdseq_fifo
// Two-entry word queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdseq_fifo #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 2'd1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/lcdseq_core.sv]
// ----------------------------------------------------------------------------
// lcdseq_core
// Pin sequencer: one tick word per step, drives the LCD pin levels, runs the
// power-up and glyph load, then writes offered bytes as two nibbles.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdseq_core #(
   parameter int GLYPH_ROM_BYTES = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [3:0]          csr_index,
   input  wire logic [15:0]         csr_write_data,
   input  wire logic                step,
   input  wire lcdseq_pkg::req_type item,
   output lcdseq_pkg::rsp_type      result
);

   import lcdseq_pkg::*;

   localparam logic [6:0] STEP_LAST_CMD = STEP_GLYPH_START + 7'(GLYPH_ROM_BYTES);
   localparam logic [6:0] STEP_DONE     = STEP_LAST_CMD + 7'd1;

   logic [15:0] unit_ticks_ff;
   logic [7:0]  long_wait_ff;

   phase_type   phase_ff, phase_in;
   logic [6:0]  init_step_ff, init_step_in;
   logic [15:0] tick_ff, tick_in;
   logic [7:0]  unit_ff, unit_in;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic        held_sel_ff, held_sel_in;
   logic        rs_ff, rs_in;
   logic        rw_ff, rw_in;
   logic        en_ff, en_in;
   logic [3:0]  nibble_ff, nibble_in;
   logic        drive_ff, drive_in;

   logic [15:0] ut_eff;
   logic [7:0]  lw_eff;
   logic [7:0]  seg_units;
   logic        tick_end, unit_end, seg_done;
   logic [15:0] seg_tick;
   logic [7:0]  seg_unit;
   logic        is_idle, acc;

   logic [6:0]  launch_step;
   logic        launch_wake;
   logic        launch_byte_ok;
   logic [6:0]  glyph_off;
   logic [6:0]  cmd_off;
   logic [7:0]  launch_byte;
   logic        launch_sel;
   phase_type   launch_phase;
   logic        busy_exit;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff <= UNIT_TICKS_RESET;
         long_wait_ff  <= LONG_WAIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_UNIT_TICKS: unit_ticks_ff <= csr_write_data;
            CSR_LONG_WAIT:  long_wait_ff  <= csr_write_data[7:0];
            default:        ;
         endcase
      end
   end

   // delay timer, zero lengths act as one
   always_comb begin
      ut_eff    = (unit_ticks_ff == 16'd0) ? 16'd1 : unit_ticks_ff;
      lw_eff    = (long_wait_ff == 8'd0) ? 8'd1 : long_wait_ff;
      seg_units = (phase_ff == PH_PWR_WAIT || phase_ff == PH_GAP) ? lw_eff : 8'd1;
      tick_end  = ({1'b0, tick_ff} + 17'd1) >= {1'b0, ut_eff};
      unit_end  = ({1'b0, unit_ff} + 9'd1) >= {1'b0, seg_units};
      seg_done  = tick_end && unit_end;
      if (tick_end) begin
         seg_tick = 16'd0;
         seg_unit = unit_end ? 8'd0 : unit_ff + 8'd1;
      end else begin
         seg_tick = tick_ff + 16'd1;
         seg_unit = unit_ff;
      end
   end

   assign is_idle   = (phase_ff == PH_IDLE);
   assign acc       = is_idle && item.write_request;
   assign busy_exit = seg_done && !item.busy_pin;

   // what the next init step loads
   always_comb begin
      launch_step    = (phase_ff == PH_PWR_WAIT) ? 7'd0 : init_step_ff + 7'd1;
      launch_wake    = (launch_step <= STEP_LAST_WAKE);
      launch_byte_ok = !launch_wake && (launch_step < STEP_DONE);
      glyph_off      = launch_step - STEP_GLYPH_START;
      cmd_off        = launch_step - STEP_FIRST_CMD;
      launch_sel     = 1'b0;
      if (launch_step < STEP_GLYPH_START) begin
         launch_byte = init_cmd(cmd_off[2:0]);
      end else if (launch_step < STEP_LAST_CMD) begin
         launch_byte = glyph_byte(glyph_off[5:0]);
         launch_sel  = 1'b1;
      end else begin
         launch_byte = CMD_DDRAM_HOME;
      end
      if (launch_wake) begin
         launch_phase = PH_NIB_L1;
      end else if (launch_byte_ok) begin
         launch_phase = PH_HI_L1;
      end else begin
         launch_phase = PH_IDLE;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_PWR_WAIT: if (seg_done) phase_in = launch_phase;
         PH_NIB_L1:   if (seg_done) phase_in = PH_NIB_H;
         PH_NIB_H:    if (seg_done) phase_in = PH_NIB_L2;
         PH_NIB_L2: begin
            if (seg_done) phase_in = (init_step_ff < STEP_LAST_GAP) ? PH_GAP : PH_BUSY;
         end
         PH_GAP:      if (seg_done) phase_in = launch_phase;
         PH_HI_L1:    if (seg_done) phase_in = PH_HI_H;
         PH_HI_H:     if (seg_done) phase_in = PH_HI_L2;
         PH_HI_L2:    if (seg_done) phase_in = PH_LO_L1;
         PH_LO_L1:    if (seg_done) phase_in = PH_LO_H;
         PH_LO_H:     if (seg_done) phase_in = PH_LO_L2;
         PH_LO_L2:    if (seg_done) phase_in = PH_BUSY;
         PH_BUSY: begin
            if (busy_exit) phase_in = (init_step_ff < STEP_DONE) ? launch_phase : PH_IDLE;
         end
         PH_IDLE:     if (acc) phase_in = PH_HI_L1;
         default:     phase_in = PH_IDLE;
      endcase
   end

   // counters, held byte and pin levels
   always_comb begin
      init_step_in = init_step_ff;
      tick_in      = seg_tick;
      unit_in      = seg_unit;
      held_byte_in = held_byte_ff;
      held_sel_in  = held_sel_ff;
      rs_in        = rs_ff;
      rw_in        = rw_ff;
      en_in        = en_ff;
      nibble_in    = nibble_ff;
      drive_in     = drive_ff;
      case (phase_ff)
         PH_PWR_WAIT, PH_GAP: begin
            if (seg_done) begin
               init_step_in = launch_step;
               if (launch_wake) begin
                  nibble_in = (launch_step == STEP_LAST_WAKE) ? FOUR_BIT_NIBBLE
                                                              : WAKE_NIBBLE;
               end else if (launch_byte_ok) begin
                  held_byte_in = launch_byte;
                  held_sel_in  = launch_sel;
                  rs_in        = launch_sel;
                  en_in        = 1'b0;
                  nibble_in    = launch_byte[7:4];
               end
            end
         end
         PH_NIB_L1, PH_HI_L1, PH_LO_L1: begin
            if (seg_done) en_in = 1'b1;
         end
         PH_NIB_H, PH_HI_H, PH_LO_H: begin
            if (seg_done) en_in = 1'b0;
         end
         PH_NIB_L2, PH_LO_L2: begin
            if (seg_done && (phase_ff == PH_LO_L2 || init_step_ff >= STEP_LAST_GAP)) begin
               rs_in    = 1'b0;
               drive_in = 1'b0;
               rw_in    = 1'b1;
               en_in    = 1'b1;
            end
         end
         PH_HI_L2: begin
            if (seg_done) nibble_in = held_byte_ff[3:0];
         end
         PH_BUSY: begin
            if (busy_exit) begin
               en_in    = 1'b0;
               rw_in    = 1'b0;
               drive_in = 1'b1;
               if (init_step_ff < STEP_DONE) begin
                  init_step_in = launch_step;
                  if (launch_wake) begin
                     nibble_in = (launch_step == STEP_LAST_WAKE) ? FOUR_BIT_NIBBLE
                                                                 : WAKE_NIBBLE;
                  end else if (launch_byte_ok) begin
                     held_byte_in = launch_byte;
                     held_sel_in  = launch_sel;
                     rs_in        = launch_sel;
                     nibble_in    = launch_byte[7:4];
                  end
               end
            end
         end
         PH_IDLE: begin
            tick_in = tick_ff;
            unit_in = unit_ff;
            if (acc) begin
               tick_in      = 16'd0;
               unit_in      = 8'd0;
               held_byte_in = item.byte_value;
               held_sel_in  = item.register_select;
               rs_in        = item.register_select;
               en_in        = 1'b0;
               nibble_in    = item.byte_value[7:4];
            end
         end
         default: begin
            tick_in = 16'd0;
            unit_in = 8'd0;
         end
      endcase
   end

   // result word shows the levels in force during this tick
   always_comb begin
      result.accepted     = acc;
      result.ready_res    = is_idle;
      result.rs_level     = rs_ff;
      result.rw_level     = rw_ff;
      result.enable_level = en_ff;
      result.data_nibble  = nibble_ff;
      result.data_drive   = drive_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_PWR_WAIT;
         init_step_ff <= 7'd0;
         tick_ff      <= 16'd0;
         unit_ff      <= 8'd0;
         held_byte_ff <= 8'd0;
         held_sel_ff  <= 1'b0;
         rs_ff        <= 1'b0;
         rw_ff        <= 1'b0;
         en_ff        <= 1'b0;
         nibble_ff    <= 4'd0;
         drive_ff     <= 1'b1;
      end else if (step) begin
         phase_ff     <= phase_in;
         init_step_ff <= init_step_in;
         tick_ff      <= tick_in;
         unit_ff      <= unit_in;
         held_byte_ff <= held_byte_in;
         held_sel_ff  <= held_sel_in;
         rs_ff        <= rs_in;
         rw_ff        <= rw_in;
         en_ff        <= en_in;
         nibble_ff    <= nibble_in;
         drive_ff     <= drive_in;
      end
   end

endmodule

`default_nettype wire
